[sv/pcg_pkg.sv]
// ----------------------------------------------------------------------------
// pcg_pkg: shared types and constants for the pixel color grade block
// Pixel beat structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package pcg_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } out_pix_t;

  // Configuration port.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgAddrW-1:0] RegBrightness = 2'd0;
  localparam logic [CfgAddrW-1:0] RegContrast   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegSaturation = 2'd2;

  localparam logic [8:0] BrightnessReset = 9'd0;
  localparam logic [9:0] ContrastReset   = 10'd256;
  localparam logic [9:0] SaturationReset = 10'd256;

  // Pipeline depth: one register rank per entry.
  localparam int unsigned NumStages = 6;

  // Per-stage load enables handed from the controller to the datapath.
  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

endpackage

[sv/pixel_color_grade.sv]
// ----------------------------------------------------------------------------
// pixel_color_grade: brightness, contrast and saturation on RGBA8 pixels
// Each beat carries one pixel. Every color channel gets contrast about
// mid-grey, then the brightness offset, then a saturation mix toward Rec.601
// luma (Q8 weights 77/150/29); all intermediates are signed Q8, each product
// and the final result are rounded half up, and only the final result is
// clamped to 0..255. Alpha is copied. The datapath is a six-stage pipeline
// that takes one pixel per clock when the output side is ready. The luma
// stage holds three multiplies and their sum; the saturation multiply is
// 21x11. Each stage loads whenever it is empty, so the input keeps accepting
// beats while results wait at the output until the pipeline is full.
// Configuration writes take effect at once and are expected only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module pixel_color_grade (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Pixel input channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pcg_pkg::in_pix_t                    in_pix_i,
  // Pixel output channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pcg_pkg::out_pix_t                   out_pix_o,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [pcg_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [pcg_pkg::CfgDataW-1:0]        cfg_data_i
);

  // Mid-grey in Q8 and the luma weights, sized for the signed products.
  localparam logic signed [19:0] MidQ8 = 20'sd32640;
  localparam logic signed [17:0] MidQ8Wide = 18'sd32640;
  localparam logic signed [27:0] LumaR = 28'sd77;
  localparam logic signed [27:0] LumaG = 28'sd150;
  localparam logic signed [27:0] LumaB = 28'sd29;
  localparam logic signed [27:0] HalfLsb28 = 28'sd128;
  localparam logic signed [31:0] HalfLsb32 = 32'sd128;
  localparam logic signed [24:0] HalfLsb25 = 25'sd128;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [8:0] bri_q;
  logic [9:0] con_q;
  logic [9:0] sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bri_q <= pcg_pkg::BrightnessReset;
      con_q <= pcg_pkg::ContrastReset;
      sat_q <= pcg_pkg::SaturationReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pcg_pkg::RegBrightness: bri_q <= cfg_data_i[8:0];
        pcg_pkg::RegContrast:   con_q <= cfg_data_i;
        pcg_pkg::RegSaturation: sat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control.
  // --------------------------------------------------------------------------
  pcg_pkg::pipe_ctrl_t ctrl;

  pcg_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // Alpha rides along through every stage.
  logic [7:0] alpha_q [pcg_pkg::NumStages];

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      alpha_q[0] <= in_pix_i.alpha_in;
    end
    for (int k = 1; k < pcg_pkg::NumStages; k++) begin
      if (ctrl.load[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  logic [7:0] chan_in [3];
  assign chan_in[0] = in_pix_i.red_in;
  assign chan_in[1] = in_pix_i.green_in;
  assign chan_in[2] = in_pix_i.blue_in;

  // --------------------------------------------------------------------------
  // Stage 1: contrast product (c*256 - mid) * contrast_gain.
  // --------------------------------------------------------------------------
  logic signed [17:0] dev    [3];
  logic signed [10:0] con_s;
  logic signed [27:0] cprod_q [3];

  assign con_s = $signed({1'b0, con_q});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dev[k] = $signed({2'b00, chan_in[k], 8'h00}) - MidQ8Wide;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      for (int k = 0; k < 3; k++) begin
        cprod_q[k] <= 28'(dev[k]) * 28'(con_s);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: round the contrast product, restore mid-grey, add brightness.
  // --------------------------------------------------------------------------
  logic signed [27:0] cround [3];
  logic signed [19:0] bri_q8;
  logic signed [19:0] x2_q   [3];

  assign bri_q8 = $signed({{3{bri_q[8]}}, bri_q, 8'h00});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cround[k] = cprod_q[k] + HalfLsb28;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[1]) begin
      for (int k = 0; k < 3; k++) begin
        x2_q[k] <= $signed(cround[k][27:8]) + MidQ8 + bri_q8;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: weighted luma sum, channels carried along.
  // --------------------------------------------------------------------------
  logic signed [27:0] lsum_q;
  logic signed [19:0] x3_q [3];

  always_ff @(posedge clk_i) begin
    if (ctrl.load[2]) begin
      lsum_q <= LumaR * 28'(x2_q[0]) + LumaG * 28'(x2_q[1]) + LumaB * 28'(x2_q[2]);
      x3_q   <= x2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round luma and form each channel's distance from it.
  // --------------------------------------------------------------------------
  logic signed [27:0] lround;
  logic signed [19:0] luma;
  logic signed [19:0] y4_q;
  logic signed [20:0] diff_q [3];

  assign lround = lsum_q + HalfLsb28;
  assign luma   = $signed(lround[27:8]);

  always_ff @(posedge clk_i) begin
    if (ctrl.load[3]) begin
      y4_q <= luma;
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= $signed({x3_q[k][19], x3_q[k]}) - $signed({luma[19], luma});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: saturation product.
  // --------------------------------------------------------------------------
  logic signed [10:0] sat_s;
  logic signed [31:0] sprod_q [3];
  logic signed [19:0] y5_q;

  assign sat_s = $signed({1'b0, sat_q});

  always_ff @(posedge clk_i) begin
    if (ctrl.load[4]) begin
      y5_q <= y4_q;
      for (int k = 0; k < 3; k++) begin
        sprod_q[k] <= 32'(diff_q[k]) * 32'(sat_s);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: add luma back, round to a code and clamp into the output
  // register.
  // --------------------------------------------------------------------------
  logic signed [31:0] sround [3];
  logic signed [24:0] zsum   [3];
  logic signed [24:0] zround [3];
  logic signed [16:0] code   [3];
  logic [7:0]         clamped [3];
  logic [7:0]         res_q   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sround[k] = sprod_q[k] + HalfLsb32;
      zsum[k]   = $signed({{5{y5_q[19]}}, y5_q}) + $signed({sround[k][31], sround[k][31:8]});
      zround[k] = zsum[k] + HalfLsb25;
      code[k]   = $signed(zround[k][24:8]);
      if (code[k][16]) begin
        clamped[k] = 8'h00;
      end else if (code[k][15:8] != 8'h00) begin
        clamped[k] = 8'hFF;
      end else begin
        clamped[k] = code[k][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[5]) begin
      res_q <= clamped;
    end
  end

  assign out_pix_o.red_out   = res_q[0];
  assign out_pix_o.green_out = res_q[1];
  assign out_pix_o.blue_out  = res_q[2];
  assign out_pix_o.alpha_out = alpha_q[pcg_pkg::NumStages-1];

endmodule

[sv/pcg_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// pcg_pipe_ctrl: valid and load control for the grading pipeline
// Tracks one valid bit per stage; a stage loads when it is empty or when the
// stage after it loads, so bubbles are squeezed out under backpressure.
// ----------------------------------------------------------------------------
module pcg_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcg_pkg::pipe_ctrl_t ctrl_o
);

  logic [pcg_pkg::NumStages-1:0] valid_q, valid_d;
  logic [pcg_pkg::NumStages-1:0] load;

  always_comb begin
    load[pcg_pkg::NumStages-1] = !valid_q[pcg_pkg::NumStages-1] || out_ready_i;
    for (int k = pcg_pkg::NumStages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < pcg_pkg::NumStages; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = load[0];
  assign out_valid_o  = valid_q[pcg_pkg::NumStages-1];
  assign ctrl_o.load  = load;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for pixel_color_grade
// Streams RGBA8 pixels through the grading pipeline under several register
// settings, predicts every graded pixel in fixed point and compares each
// output beat against the oldest prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  // Midpoint of the code range in Q8 (127.5 * 256) and the Rec.601 Q8 weights.
  localparam longint MidQ8 = 32640;
  localparam longint LumaR = 77;
  localparam longint LumaG = 150;
  localparam longint LumaB = 29;

  // The address space has one index past the last register; writes there are
  // dropped by the block.
  localparam logic [pcg_pkg::CfgAddrW-1:0] RegUnused = 2'd3;

  // Cycles without any accepted beat or register write before the run is
  // declared hung. Random stalls are short, so this is a wide margin.
  localparam int unsigned StallLimit = 2000;

  localparam int unsigned RandomPhases   = 10;
  localparam int unsigned PixelsPerPhase = 125;

  logic     clk_i    = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  pcg_pkg::in_pix_t  in_pix   = '0;
  logic     out_ready = 1'b0;
  logic     cfg_we   = 1'b0;
  logic [pcg_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [pcg_pkg::CfgDataW-1:0] cfg_data = '0;

  logic     in_ready;
  logic     out_valid;
  pcg_pkg::out_pix_t out_pix;

  // Shadow copy of the three grading registers, as the block holds them.
  logic signed [8:0] bright_q     = pcg_pkg::BrightnessReset;
  logic        [9:0] contrast_q   = pcg_pkg::ContrastReset;
  logic        [9:0] saturation_q = pcg_pkg::SaturationReset;

  // Graded pixels still owed by the block, oldest first.
  pcg_pkg::out_pix_t graded_q[$];
  pcg_pkg::out_pix_t want_pix;

  int unsigned mismatches = 0;
  int unsigned stall_cnt  = 0;

  // While set, neither side idles: the sender streams and the sink never stalls.
  bit calm = 1'b0;

  pixel_color_grade u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_pix_i    (in_pix),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_pix_o   (out_pix),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Round half up out of Q8. The arithmetic shift of a signed value is a
  // floor, which is what the block does for negative intermediates too.
  function automatic longint round_q8(input longint v);
    return (v + 128) >>> 8;
  endfunction

  function automatic logic [7:0] clamp_code(input longint z);
    longint o;
    o = round_q8(z);
    if (o < 0) o = 0;
    if (o > 255) o = 255;
    return o[7:0];
  endfunction

  // Grade one pixel with the current shadow registers. Contrast works on the
  // distance from mid-grey, brightness adds whole codes, and the saturation
  // mix pulls each channel toward (or pushes it away from) the luma. Nothing
  // is clamped until the final rounding.
  function automatic pcg_pkg::out_pix_t grade_pixel(input pcg_pkg::in_pix_t p);
    longint   bri;
    longint   con;
    longint   sat;
    longint   chan[3];
    longint   lin[3];
    longint   luma;
    pcg_pkg::out_pix_t r;
    bri = longint'(bright_q);
    con = longint'(contrast_q);
    sat = longint'(saturation_q);
    chan[0] = longint'(p.red_in);
    chan[1] = longint'(p.green_in);
    chan[2] = longint'(p.blue_in);
    for (int k = 0; k < 3; k++) begin
      lin[k] = round_q8((chan[k] * 256 - MidQ8) * con) + MidQ8 + bri * 256;
    end
    luma = round_q8(LumaR * lin[0] + LumaG * lin[1] + LumaB * lin[2]);
    r.red_out   = clamp_code(luma + round_q8((lin[0] - luma) * sat));
    r.green_out = clamp_code(luma + round_q8((lin[1] - luma) * sat));
    r.blue_out  = clamp_code(luma + round_q8((lin[2] - luma) * sat));
    r.alpha_out = p.alpha_in;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one pixel beat and record its graded value once it is accepted.
  // On return valid is still high; the next call either keeps it high with
  // new data or drops it for a gap, and flush_pipe drops it at the end of a
  // burst. That way valid gets a single assignment in any one time step.
  task automatic push_pixel(input pcg_pkg::in_pix_t pix);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_pix   <= pix;
    do @(posedge clk_i); while (!in_ready);
    graded_q.push_back(grade_pixel(pix));
  endtask

  // End a burst: stop sending, wait for every graded pixel, then keep clocking
  // the idle pipeline so a stray extra beat would still be caught.
  task automatic flush_pipe();
    in_valid <= 1'b0;
    while (graded_q.size() != 0) @(posedge clk_i);
    repeat (pcg_pkg::NumStages + 4) @(posedge clk_i);
  endtask

  // Program all three grading registers, then poke the unused index, which
  // must not disturb anything. The brightness write carries a random spare
  // top bit, since only the low nine bits are meant to be kept.
  task automatic set_grade(input logic signed [8:0] bri, input logic [9:0] con,
                           input logic [9:0] sat);
    logic spare_bit;
    spare_bit = 1'($urandom_range(1));
    cfg_we   <= 1'b1;
    cfg_addr <= pcg_pkg::RegBrightness;
    cfg_data <= {spare_bit, bri};
    @(posedge clk_i);
    bright_q = bri;
    cfg_addr <= pcg_pkg::RegContrast;
    cfg_data <= con;
    @(posedge clk_i);
    contrast_q = con;
    cfg_addr <= pcg_pkg::RegSaturation;
    cfg_data <= sat;
    @(posedge clk_i);
    saturation_q = sat;
    cfg_addr <= RegUnused;
    cfg_data <= pcg_pkg::CfgDataW'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic pcg_pkg::in_pix_t make_pix(input int r, input int g, input int b,
                                                input int a);
    pcg_pkg::in_pix_t p;
    p.red_in   = r[7:0];
    p.green_in = g[7:0];
    p.blue_in  = b[7:0];
    p.alpha_in = a[7:0];
    return p;
  endfunction

  // Channel codes biased toward the ends of the range and mid-grey, where
  // rounding and clamping are most likely to go wrong.
  function automatic logic [7:0] edgy_code();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pcg_pkg::in_pix_t rand_pixel();
    pcg_pkg::in_pix_t p;
    if ($urandom_range(99) < 70) begin
      p = pcg_pkg::in_pix_t'($urandom);
    end else begin
      p.red_in   = edgy_code();
      p.green_in = edgy_code();
      p.blue_in  = edgy_code();
      p.alpha_in = edgy_code();
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sink and checking
  // ---------------------------------------------------------------------------

  // The sink stalls about a quarter of the time unless the run is calm.
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  task automatic report_fault(input string what, input pcg_pkg::out_pix_t exp_v,
                              input pcg_pkg::out_pix_t got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
               what, exp_v.red_out, exp_v.green_out, exp_v.blue_out, exp_v.alpha_out,
               got_v.red_out, got_v.green_out, got_v.blue_out, got_v.alpha_out);
    end
  endtask

  // Every accepted output beat is matched against the oldest graded pixel.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      if (graded_q.size() == 0) begin
        report_fault("beat with nothing pending", '0, out_pix);
      end else begin
        want_pix = graded_q.pop_front();
        if (out_pix.red_out !== want_pix.red_out ||
            out_pix.green_out !== want_pix.green_out ||
            out_pix.blue_out !== want_pix.blue_out ||
            out_pix.alpha_out !== want_pix.alpha_out) begin
          report_fault("pixel mismatch", want_pix, out_pix);
        end
      end
    end
  end

  // Count cycles in which nothing moves; any beat or register write resets it.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : watchdog
    while (stall_cnt < StallLimit) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the registers are at unity, so every pixel must pass as is.
  task automatic test_reset_identity();
    push_pixel(make_pix(0, 0, 0, 0));
    push_pixel(make_pix(255, 255, 255, 255));
    push_pixel(make_pix(12, 200, 99, 90));
    push_pixel(make_pix(128, 127, 1, 254));
    flush_pipe();
  endtask

  // Register extremes, including values past the documented range, each with
  // a handful of pixels; most groups hit black, white, mid-grey or pure primaries.
  task automatic test_register_extremes();
    // Weakest contrast squeezes everything toward mid-grey.
    set_grade(9'sd0, 10'd128, 10'd256);
    push_pixel(make_pix(0, 0, 0, 17));
    push_pixel(make_pix(255, 255, 255, 200));
    push_pixel(make_pix(127, 128, 64, 0));
    flush_pipe();
    // Strongest in-range settings: white and primaries saturate high.
    set_grade(9'sd255, 10'd512, 10'd512);
    push_pixel(make_pix(255, 255, 255, 255));
    push_pixel(make_pix(255, 0, 0, 1));
    push_pixel(make_pix(128, 128, 128, 128));
    flush_pipe();
    // Darkest offset with full grey: white lands on mid-grey, the darker pixels on the low clamp.
    set_grade(-9'sd255, 10'd512, 10'd0);
    push_pixel(make_pix(255, 255, 255, 3));
    push_pixel(make_pix(0, 255, 0, 250));
    push_pixel(make_pix(200, 100, 50, 77));
    flush_pipe();
    // Out-of-range values: brightness -256 and gains up to 1023.
    set_grade(-9'sd256, 10'd1023, 10'd1023);
    push_pixel(make_pix(255, 255, 255, 0));
    push_pixel(make_pix(0, 0, 255, 255));
    push_pixel(make_pix(130, 125, 250, 42));
    flush_pipe();
    // Zero saturation is plain grayscale from the luma weights.
    set_grade(9'sd0, 10'd256, 10'd0);
    push_pixel(make_pix(255, 0, 0, 10));
    push_pixel(make_pix(0, 255, 0, 20));
    push_pixel(make_pix(0, 0, 255, 30));
    flush_pipe();
    // A middling mix with a moderate oversaturation.
    set_grade(9'sd100, 10'd300, 10'd700);
    push_pixel(rand_pixel());
    push_pixel(rand_pixel());
    flush_pipe();
  endtask

  // Random settings per phase, random pixels within each phase. Most phases
  // keep the registers in range; now and then a register takes any value its
  // width allows. One phase runs with no idling at all on either side.
  task automatic test_random_streams();
    logic signed [8:0] bri;
    logic        [9:0] con;
    logic        [9:0] sat;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      bri = ($urandom_range(99) < 80) ? 9'($urandom_range(510) - 255) : 9'($urandom);
      con = ($urandom_range(99) < 80) ? 10'($urandom_range(512, 128)) : 10'($urandom);
      sat = ($urandom_range(99) < 80) ? 10'($urandom_range(512)) : 10'($urandom);
      set_grade(bri, con, sat);
      calm = (ph == 3);
      for (int n = 0; n < PixelsPerPhase; n++) begin
        push_pixel(rand_pixel());
      end
      flush_pipe();
      calm = 1'b0;
    end
    // Back to unity so the final stretch checks the identity path again.
    set_grade(pcg_pkg::BrightnessReset, pcg_pkg::ContrastReset, pcg_pkg::SaturationReset);
    for (int n = 0; n < 40; n++) begin
      push_pixel(rand_pixel());
    end
    flush_pipe();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_identity();
    test_register_extremes();
    test_random_streams();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[pixel_color_grade.f]
sv/pcg_pkg.sv
sv/pcg_pipe_ctrl.sv
sv/pixel_color_grade.sv
test/tb.sv
